/* rtl/fpa_pkg.sv */
// shared types and constants of the free-list page allocator
// no dependencies; used by fpa_result_q and free_list_page_allocator_top
package fpa_pkg;

	localparam int PAGE_W        = 10;
	localparam int PAGE_N        = 1 << PAGE_W;
	localparam int MAX_PAGES_DEF = 1024;

	typedef enum logic [0:0] {
		FUNC_ALLOC = 1'b0,
		FUNC_FREE  = 1'b1
	} fpa_func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_PAGE = 2'd1,
		ST_FULL     = 2'd2
	} fpa_status_t;

	typedef enum logic [0:0] {
		S_IDLE = 1'b0,
		S_LINK = 1'b1
	} fpa_state_t;

	typedef struct packed {
		fpa_status_t       status;
		logic [PAGE_W-1:0] given_page;
	} fpa_result_t;

endpackage

/* rtl/free_list_page_allocator_top.sv */
// free-list page allocator: lifo free list in a link memory plus a high-water page count
// depends on fpa_pkg and fpa_result_q
//
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/tready        tuser[0] func, tdata[9:0] page_id
// m_axis    out  m_axis_tvalid/tready        tuser[1:0] status, tdata[9:0] given_page
//
// a free, a fresh allocate and any rejected request leave the core in S_IDLE
// an allocate that pops the free list passes through S_LINK: the link memory read
// is registered, so the new head is known only in S_LINK
// reset clears the head and its valid bit and sets the page count to 1; the link
// memory is not cleared, an entry is always written by a free before it is read
// up to two results are queued, so input keeps flowing while a result waits
module free_list_page_allocator_top
	import fpa_pkg::*;
#(
	parameter int MAX_PAGES = MAX_PAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [9:0] page_id, rest zero
	input  logic [0:0]  s_axis_tuser,   // [0] func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [9:0] given_page, rest zero
	output logic [1:0]  m_axis_tuser    // [1:0] status
);

	// page count must hold MAX_PAGES itself
	localparam int CNT_W      = $clog2(MAX_PAGES + 1);
	// only pages below 2**PAGE_W can ever be freed, so links stop there
	localparam int LINK_DEPTH = (MAX_PAGES < PAGE_N) ? MAX_PAGES : PAGE_N;
	localparam int IDX_W      = $clog2(LINK_DEPTH);
	localparam int CMP_W      = (CNT_W > PAGE_W) ? CNT_W : PAGE_W;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAGES);

	// link memory, one next pointer per page
	logic [PAGE_W-1:0] link_mem [LINK_DEPTH];
	logic [PAGE_W-1:0] link_rd_q;

	fpa_state_t        state_q, state_d;
	logic [PAGE_W-1:0] free_head_q;
	logic              free_head_valid_q;
	logic [CNT_W-1:0]  page_count_q;

	logic              q_full;
	logic              accept;
	fpa_func_t         func;
	logic [PAGE_W-1:0] page_id;
	logic              bad_page;
	logic              can_grow;
	logic              do_pop;
	logic              do_grow;
	logic              do_push;
	fpa_result_t       result;
	fpa_result_t       out_result;

	assign func    = fpa_func_t'(s_axis_tuser[0]);
	assign page_id = s_axis_tdata[PAGE_W-1:0];
	assign accept  = s_axis_tvalid && s_axis_tready;

	// page 0 is reserved; anything at or above the count was never handed out
	assign bad_page = (page_id == '0) || (CMP_W'(page_id) >= CMP_W'(page_count_q));
	assign can_grow = (page_count_q < MAX_CNT);

	// result is known at accept time; only the head update of a pop waits
	always_comb begin
		state_d           = state_q;
		s_axis_tready     = (state_q == S_IDLE) && !q_full;
		do_pop            = 1'b0;
		do_grow           = 1'b0;
		do_push           = 1'b0;
		result.status     = ST_OK;
		result.given_page = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (func == FUNC_ALLOC) begin
						if (free_head_valid_q) begin
							do_pop            = 1'b1;
							result.given_page = free_head_q;
							state_d           = S_LINK;
						end else if (can_grow) begin
							do_grow           = 1'b1;
							result.given_page = PAGE_W'(page_count_q);
						end else begin
							result.status = ST_FULL;
						end
					end else begin
						if (bad_page) begin
							result.status = ST_BAD_PAGE;
						end else begin
							do_push = 1'b1;
						end
					end
				end
			end
			S_LINK: begin
				// link read of the popped page lands this cycle
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q       <= '0;
			free_head_valid_q <= 1'b0;
			page_count_q      <= CNT_W'(1);
		end else begin
			if (state_q == S_LINK) begin
				// a link of zero marks the end of the list
				free_head_q       <= link_rd_q;
				free_head_valid_q <= (link_rd_q != '0);
			end else if (do_push) begin
				free_head_q       <= page_id;
				free_head_valid_q <= 1'b1;
			end
			if (do_grow) page_count_q <= page_count_q + CNT_W'(1);
		end
	end

	// link memory: write on a free, read the head's link on a pop
	always_ff @(posedge clk) begin
		if (do_push) begin
			link_mem[page_id[IDX_W-1:0]] <= free_head_valid_q ? free_head_q : '0;
		end
		if (do_pop) begin
			link_rd_q <= link_mem[free_head_q[IDX_W-1:0]];
		end
	end

	fpa_result_q u_result_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (result),
		.full      (q_full),
		.pop_valid (m_axis_tvalid),
		.pop_ready (m_axis_tready),
		.pop_data  (out_result)
	);

	assign m_axis_tdata = {{(16 - PAGE_W){1'b0}}, out_result.given_page};
	assign m_axis_tuser = out_result.status;

endmodule

/* rtl/fpa_result_q.sv */
// two-entry result queue between the allocator core and the output stream
// depends on fpa_pkg for the result type
module fpa_result_q
	import fpa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  fpa_result_t push_data,
	output logic        full,
	output logic        pop_valid,
	input  logic        pop_ready,
	output fpa_result_t pop_data
);

	fpa_result_t slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        pop;

	assign pop       = pop_valid && pop_ready;
	assign pop_valid = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

endmodule
